// ===== hw/rtl/datagram_stream_deframer_macros.svh =====
// Assertion helpers for the deframer checker.
`ifndef DATAGRAM_STREAM_DEFRAMER_MACROS_SVH
`define DATAGRAM_STREAM_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define DSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== hw/rtl/dsd_pkg.sv =====
`timescale 1ns / 1ps
package dsd_pkg;
  localparam int unsigned BufAddrW = 16;
  localparam int unsigned RdySlots = 16;
  localparam int unsigned RdyIdxW  = 4;
  localparam int unsigned RdyCntW  = 5;
  localparam int unsigned LenW     = 14;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [7:0] HeadMark  = 8'hab;
  localparam logic [7:0] TailMark  = 8'hbc;
  localparam logic [7:0] CheckSeed = 8'hff;

  localparam logic [2:0] IdxCheck = 3'd5;
  localparam logic [BufAddrW-1:0] HdrBytes   = 16'd6;
  localparam logic [BufAddrW-1:0] FrameExtra = 16'd7;
  localparam logic [BufAddrW-1:0] RingFull   = 16'hffff;

  localparam logic [1:0] KindPush  = 2'd0;
  localparam logic [1:0] KindData  = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;

  localparam logic [CfgIdxW-1:0] RegMaxLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinLength = 2'd1;

  localparam logic [LenW-1:0] MaxLengthRst = 14'd8192;
  localparam logic [LenW-1:0] MinLengthRst = 14'd14;

  typedef struct packed {
    logic [BufAddrW-1:0] start;
    logic [LenW-1:0]     len;
  } rdy_entry_t;

  typedef struct packed {
    logic [RdyCntW-1:0] count;
    rdy_entry_t         head;
  } rdy_status_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    rdy_entry_t entry;
  } rdy_ctrl_t;
endpackage

// ===== hw/rtl/dsd_ifs.sv =====
`timescale 1ns / 1ps
interface dsd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] stream_byte;
  modport source (output valid, mode, stream_byte, input ready);
  modport sink (input valid, mode, stream_byte, output ready);
endinterface

interface dsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic [4:0]  ready_count;
  logic [31:0] framing_errors;
  logic [31:0] runt_count;
  modport source (output valid, kind, payload_byte, last_byte, ready_count,
                  framing_errors, runt_count, input ready);
  modport sink (input valid, kind, payload_byte, last_byte, ready_count,
                framing_errors, runt_count, output ready);
endinterface

interface dsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dsd_buf_mem.sv =====
`timescale 1ns / 1ps
module dsd_buf_mem
  import dsd_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [BufAddrW-1:0] waddr_i,
  input  logic [7:0]          wdata_i,
  input  logic [BufAddrW-1:0] raddr_i,
  output logic [7:0]          rdata_o
);
  logic [7:0] mem [2**BufAddrW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/dsd_ready_q.sv =====
`timescale 1ns / 1ps
module dsd_ready_q
  import dsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rdy_ctrl_t   ctrl_i,
  output rdy_status_t status_o
);
  rdy_entry_t         slots_q [RdySlots];
  logic [RdyCntW-1:0] head_q;
  logic [RdyCntW-1:0] tail_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      slots_q[tail_q[RdyIdxW-1:0]] <= ctrl_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (ctrl_i.push) tail_q <= tail_q + 1'b1;
      if (ctrl_i.pop)  head_q <= head_q + 1'b1;
    end
  end

  // Pointers run modulo twice the slot count so full and empty differ.
  assign status_o.count = tail_q - head_q;
  assign status_o.head  = slots_q[head_q[RdyIdxW-1:0]];
endmodule

// ===== hw/rtl/datagram_stream_deframer.sv =====
`timescale 1ns / 1ps
// A data pop passes StPopD and StResp before its result beat is registered; an empty pop
// goes straight to StResp; a push runs the rescan, or goes to StResp if a full ring drops the byte.
// Rescan: StHdr reads each header candidate, StTail the tail, StSrch a head search byte by byte;
// the 64K x 8 stream memory has one read port, one read per cycle.
// Throughput: one item at a time; the next item is taken while a result beat waits.
// Reset: pointers, queue, counters and control clear at once; stream memory is not cleared.
module datagram_stream_deframer
  import dsd_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  dsd_in_if.sink     in_i,
  dsd_out_if.source  out_o,
  dsd_cfg_if.sink    cfg_i
);
  typedef enum logic [2:0] {
    StIdle, StScan, StHdr, StSrch, StTail, StPopD, StResp
  } state_e;

  state_e              state_q;
  logic [BufAddrW-1:0] scan_q, wp_q, off_q, avail_q, len_q;
  logic [LenW-1:0]     pop_off_q, max_q, min_q;
  logic [31:0]         err_q, runt_q;
  logic [2:0]          idx_q;
  logic [7:0]          chk_q;
  logic                hi_nz_q;
  logic [1:0]          res_kind_q;
  logic [7:0]          res_byte_q;
  logic                res_last_q;

  logic                out_valid_q, out_last_q;
  logic [1:0]          out_kind_q;
  logic [7:0]          out_byte_q;
  logic [RdyCntW-1:0]  out_cnt_q;
  logic [31:0]         out_err_q, out_runt_q;

  logic                mem_we;
  logic [BufAddrW-1:0] rd_addr;
  logic [7:0]          rdata;
  rdy_ctrl_t           rq_ctrl;
  rdy_status_t         rq_st;

  logic                in_acc, q_empty, head_full, out_free;
  logic [BufAddrW-1:0] head_addr, avail_now, tail_addr, frame_end;
  logic [BufAddrW:0]   need;
  logic                len_bad;
  logic [LenW:0]       pop_next;

  assign in_acc    = in_i.valid && in_i.ready;
  assign q_empty   = (rq_st.count == '0);
  assign head_addr = rq_st.head.start + BufAddrW'(pop_off_q);
  assign head_full = !q_empty && ((wp_q - head_addr) == RingFull);
  assign avail_now = wp_q - scan_q;
  assign tail_addr = scan_q + HdrBytes + len_q;
  assign frame_end = scan_q + FrameExtra + len_q;
  assign need      = {1'b0, FrameExtra} + {1'b0, len_q};
  assign len_bad   = hi_nz_q || (len_q > {2'b00, max_q});
  assign pop_next  = {1'b0, pop_off_q} + 1'b1;
  assign out_free  = !out_valid_q || out_o.ready;
  assign mem_we    = in_acc && !in_i.mode && !head_full;

  always_comb begin
    unique case (state_q)
      StIdle:  rd_addr = head_addr;
      StScan:  rd_addr = scan_q;
      StHdr:   rd_addr = (idx_q == IdxCheck) ? tail_addr : scan_q + BufAddrW'(idx_q) + 1'b1;
      StSrch:  rd_addr = scan_q + off_q + 1'b1;
      default: rd_addr = scan_q;
    endcase
  end

  // Queue push happens on a good tail beat of a non-runt frame while the queue has room; pop on the last byte of a pop.
  always_comb begin
    rq_ctrl.push        = (state_q == StTail) && (rdata == TailMark) &&
                          (len_q[LenW-1:0] >= min_q) && (len_q != '0) &&
                          !rq_st.count[RdyCntW-1];
    rq_ctrl.pop         = (state_q == StPopD) && (pop_next >= {1'b0, rq_st.head.len});
    rq_ctrl.entry.start = scan_q + HdrBytes;
    rq_ctrl.entry.len   = len_q[LenW-1:0];
  end

  dsd_buf_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (in_i.stream_byte),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  dsd_ready_q u_rq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rq_ctrl),
    .status_o (rq_st)
  );

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      wp_q        <= '0;
      pop_off_q   <= '0;
      err_q       <= '0;
      runt_q      <= '0;
      max_q       <= MaxLengthRst;
      min_q       <= MinLengthRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          RegMaxLength: max_q <= cfg_i.data;
          RegMinLength: min_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (out_valid_q && out_o.ready && (state_q != StResp)) out_valid_q <= 1'b0;

      unique case (state_q)
        StIdle: begin
          res_byte_q <= '0;
          res_last_q <= 1'b0;
          if (in_acc) begin
            if (!in_i.mode) begin
              res_kind_q <= KindPush;
              if ((q_empty ? avail_now : wp_q - head_addr) == RingFull) begin
                if (~&err_q) err_q <= err_q + 1'b1;
                scan_q <= wp_q;
              end
              if (!head_full) begin
                wp_q    <= wp_q + 1'b1;
                state_q <= StScan;
              end else begin
                state_q <= StResp;
              end
            end else if (q_empty) begin
              res_kind_q <= KindEmpty;
              state_q    <= StResp;
            end else begin
              res_kind_q <= KindData;
              state_q    <= StPopD;
            end
          end
        end
        StScan: begin
          if (avail_now < FrameExtra) begin
            state_q <= StResp;
          end else begin
            avail_q <= avail_now;
            idx_q   <= '0;
            state_q <= StHdr;
          end
        end
        StHdr: begin
          idx_q <= idx_q + 1'b1;
          unique case (idx_q)
            3'd0: begin
              if (rdata != HeadMark) begin
                if (~&err_q) err_q <= err_q + 1'b1;
                if (avail_q <= 16'd1) begin
                  scan_q  <= wp_q;
                  state_q <= StScan;
                end else begin
                  off_q   <= 16'd1;
                  state_q <= StSrch;
                end
              end
              chk_q   <= CheckSeed ^ rdata;
              hi_nz_q <= 1'b0;
            end
            3'd1: begin
              len_q[7:0] <= rdata;
              chk_q      <= chk_q ^ rdata;
            end
            3'd2: begin
              len_q[15:8] <= rdata;
              chk_q       <= chk_q ^ rdata;
            end
            3'd3, 3'd4: begin
              hi_nz_q <= hi_nz_q || (rdata != '0);
              chk_q   <= chk_q ^ rdata;
            end
            default: begin
              if ((chk_q != rdata) || len_bad) begin
                if (~&err_q) err_q <= err_q + 1'b1;
                scan_q  <= scan_q + 1'b1;
                state_q <= StScan;
              end else if ({1'b0, avail_q} < need) begin
                state_q <= StResp;
              end else begin
                state_q <= StTail;
              end
            end
          endcase
        end
        StSrch: begin
          if (rdata == HeadMark) begin
            scan_q  <= scan_q + off_q;
            state_q <= StScan;
          end else if (off_q + 1'b1 >= avail_q) begin
            scan_q  <= wp_q;
            state_q <= StScan;
          end else begin
            off_q <= off_q + 1'b1;
          end
        end
        StTail: begin
          state_q <= StScan;
          if (rdata != TailMark) begin
            if (~&err_q) err_q <= err_q + 1'b1;
            scan_q <= scan_q + 1'b1;
          end else begin
            scan_q <= frame_end;
            if (len_q[LenW-1:0] < min_q) begin
              if (~&runt_q) runt_q <= runt_q + 1'b1;
            end else if ((len_q != '0) && rq_st.count[RdyCntW-1]) begin
              if (~&err_q) err_q <= err_q + 1'b1;
            end
          end
        end
        StPopD: begin
          res_byte_q <= rdata;
          if (rq_ctrl.pop) begin
            res_last_q <= 1'b1;
            pop_off_q  <= '0;
          end else begin
            pop_off_q <= pop_next[LenW-1:0];
          end
          state_q <= StResp;
        end
        StResp: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= res_kind_q;
            out_byte_q  <= res_byte_q;
            out_last_q  <= res_last_q;
            out_cnt_q   <= rq_st.count;
            out_err_q   <= err_q;
            out_runt_q  <= runt_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_kind_q;
  assign out_o.payload_byte   = out_byte_q;
  assign out_o.last_byte      = out_last_q;
  assign out_o.ready_count    = out_cnt_q;
  assign out_o.framing_errors = out_err_q;
  assign out_o.runt_count     = out_runt_q;
endmodule

// ===== hw/rtl/dsd_checker.sv =====
`timescale 1ns / 1ps
`include "datagram_stream_deframer_macros.svh"
module dsd_checker
  import dsd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [4:0]  out_count
);
  `DSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))
  `DSD_ASSERT_NOW(a_kind_legal, out_valid, out_kind <= KindEmpty)
  `DSD_ASSERT_NOW(a_count_range, out_valid, out_count <= 5'd16)
  `DSD_ASSERT_NOW(a_no_data_zero, out_valid && out_kind != KindData, out_byte == 8'd0 && !out_last)
endmodule

bind datagram_stream_deframer dsd_checker u_dsd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.kind),
  .out_byte  (out_o.payload_byte),
  .out_last  (out_o.last_byte),
  .out_count (out_o.ready_count)
);
